// ===== hdl/m4vol_pkg.sv =====
`default_nettype none
package m4vol_pkg;

  localparam int ByteW = 8;
  localparam int WidthW = 13;
  localparam int ResW = 16;
  localparam int AccW = 32;
  localparam int LenW = 6;
  localparam int MatrixLen = 64;
  localparam int CntW = 7;
  localparam int OutW = 56;

  typedef enum logic [2:0] {
    ST_VOL_DONE  = 3'd0,
    ST_NON_RECT  = 3'd1,
    ST_H263      = 3'd2,
    ST_NO_VOL    = 3'd3,
    ST_TRUNCATED = 3'd4
  } status_t;

  typedef enum logic [5:0] {
    P_SEARCH, P_CODE, P_PROFILE, P_VOBJ, P_HEAD, P_IDENT, P_ASPECT, P_PAR,
    P_CTRL, P_CHROMA, P_VBVA, P_VBVB, P_VBVC, P_SHAPE, P_RES, P_FIXED,
    P_FIXINC, P_SIZEW, P_SIZEH, P_SPRITE, P_SPRA, P_SPRB, P_WARP, P_LOWLAT,
    P_NOT8, P_PREC, P_QTYPE, P_LOADI, P_MATI, P_LOADN, P_MATN, P_PRE,
    P_RESYNC, P_DP, P_RVLC, P_NEWPRED, P_SCAL, P_SCALX
  } step_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_OUT
  } ctl_t;

  // serialiser -> field walker, one bit per cycle while shifting and the output is not stalled
  typedef struct packed {
    logic bit_valid;
    logic bit_val;
    logic last_bit;
  } bit_req_t;

  typedef struct packed {
    logic    done;
    status_t status;
  } walk_rsp_t;

  typedef struct packed {
    logic [WidthW-1:0] frame_width;
    logic [WidthW-1:0] frame_height;
    logic [ResW-1:0]   tick_resolution;
    logic [ByteW-1:0]  profile_level;
    logic              resync_used;
    logic              partitioned;
    logic              reversible_vlc;
  } rec_t;

endpackage
`default_nettype wire

// ===== hdl/m4vol_walker.sv =====
`default_nettype none
module m4vol_walker (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                clear,
  input  wire m4vol_pkg::bit_req_t bit_in,
  input  wire logic                final_flag,
  output m4vol_pkg::walk_rsp_t     rsp,
  output m4vol_pkg::rec_t          rec
);
  import m4vol_pkg::*;

  logic [1:0]      search_stage, search_stage_next;
  step_t           step, step_next;
  logic [AccW-1:0] acc, acc_next, acc_sh;
  logic [LenW-1:0] bits_left, bits_left_next, bl_dec;
  logic [3:0]      obj_ver, obj_ver_next;
  logic [LenW-1:0] inc_len, inc_len_next;
  logic [1:0]      sprite, sprite_next;
  logic [CntW-1:0] mcount, mcount_next, mc_inc;
  rec_t            r, r_next;
  logic            hit;
  status_t         hit_st;
  logic            v1;

  // bit length of (res-1), at least one; 32 for zero
  function automatic logic [LenW-1:0] incr_len(input logic [ResW-1:0] res);
    logic [ResW-1:0] j;
    logic [LenW-1:0] n;
    j = res - 1'b1;
    n = '0;
    for (int k = 0; k < ResW; k++) begin
      if (j[k]) begin
        n = LenW'(k + 1);
      end
    end
    if (res == '0) begin
      n = LenW'(AccW);
    end else if (n == '0) begin
      n = LenW'(1);
    end
    return n;
  endfunction

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      search_stage <= '0;
      step <= P_SEARCH;
      acc <= '0;
      bits_left <= LenW'(ByteW);
      obj_ver <= '0;
      inc_len <= '0;
      sprite <= '0;
      mcount <= '0;
      r <= '0;
    end else begin
      search_stage <= search_stage_next;
      step <= step_next;
      acc <= acc_next;
      bits_left <= bits_left_next;
      obj_ver <= obj_ver_next;
      inc_len <= inc_len_next;
      sprite <= sprite_next;
      mcount <= mcount_next;
      r <= r_next;
    end
  end

  always_comb begin
    logic [AccW-1:0] v;
    search_stage_next = search_stage;
    step_next = step;
    acc_next = acc;
    bits_left_next = bits_left;
    obj_ver_next = obj_ver;
    inc_len_next = inc_len;
    sprite_next = sprite;
    mcount_next = mcount;
    r_next = r;
    hit = 1'b0;
    hit_st = ST_VOL_DONE;
    v1 = (obj_ver == 4'd1);
    acc_sh = {acc[AccW-2:0], bit_in.bit_val};
    bl_dec = (bits_left != '0) ? bits_left - 1'b1 : bits_left;
    mc_inc = mcount + 1'b1;
    v = acc_sh;
    if (bit_in.bit_valid) begin
      acc_next = acc_sh;
      bits_left_next = bl_dec;
      if (bl_dec == '0) begin
        acc_next = '0;
        case (step)
          P_CODE: begin
            if (v[7:4] == 4'h2 && v[31:8] == '0) begin
              step_next = P_HEAD; bits_left_next = LenW'(10);
            end else if (v == 32'hB0) begin
              step_next = P_PROFILE; bits_left_next = LenW'(8);
            end else if (v == 32'hB5) begin
              step_next = P_VOBJ; bits_left_next = LenW'(8);
            end else begin
              step_next = P_SEARCH; bits_left_next = LenW'(8);
            end
          end
          P_PROFILE: begin
            r_next.profile_level = v[7:0];
            step_next = P_SEARCH; bits_left_next = LenW'(8);
          end
          P_VOBJ: begin
            obj_ver_next = v[7] ? v[6:3] : 4'd1;
            step_next = P_SEARCH; bits_left_next = LenW'(8);
          end
          P_HEAD: begin
            if (v[0]) begin step_next = P_IDENT; bits_left_next = LenW'(7); end
            else begin step_next = P_ASPECT; bits_left_next = LenW'(4); end
          end
          P_IDENT: begin
            obj_ver_next = v[6:3];
            step_next = P_ASPECT; bits_left_next = LenW'(4);
          end
          P_ASPECT: begin
            if (v == 32'd15) begin step_next = P_PAR; bits_left_next = LenW'(16); end
            else begin step_next = P_CTRL; bits_left_next = LenW'(1); end
          end
          P_PAR: begin step_next = P_CTRL; bits_left_next = LenW'(1); end
          P_CTRL: begin
            if (v != '0) begin step_next = P_CHROMA; bits_left_next = LenW'(4); end
            else begin step_next = P_SHAPE; bits_left_next = LenW'(2); end
          end
          P_CHROMA: begin
            if (v[0]) begin step_next = P_VBVA; bits_left_next = LenW'(32); end
            else begin step_next = P_SHAPE; bits_left_next = LenW'(2); end
          end
          P_VBVA: begin step_next = P_VBVB; bits_left_next = LenW'(32); end
          P_VBVB: begin step_next = P_VBVC; bits_left_next = LenW'(15); end
          P_VBVC: begin step_next = P_SHAPE; bits_left_next = LenW'(2); end
          P_SHAPE: begin
            if (v != '0) begin
              hit = 1'b1; hit_st = ST_NON_RECT;
            end else begin
              step_next = P_RES; bits_left_next = LenW'(17);
            end
          end
          P_RES: begin
            r_next.tick_resolution = v[ResW-1:0];
            inc_len_next = incr_len(v[ResW-1:0]);
            step_next = P_FIXED; bits_left_next = LenW'(2);
          end
          P_FIXED: begin
            if (v[0]) begin
              step_next = P_FIXINC; bits_left_next = inc_len;
            end else begin
              step_next = P_SIZEW; bits_left_next = LenW'(14);
            end
          end
          P_FIXINC: begin step_next = P_SIZEW; bits_left_next = LenW'(14); end
          P_SIZEW: begin
            r_next.frame_width = v[WidthW-1:0];
            step_next = P_SIZEH; bits_left_next = LenW'(14);
          end
          P_SIZEH: begin
            r_next.frame_height = v[WidthW-1:0];
            step_next = P_SPRITE; bits_left_next = v1 ? LenW'(4) : LenW'(5);
          end
          P_SPRITE: begin
            sprite_next = v1 ? {1'b0, v[0]} : v[1:0];
            if (sprite_next == 2'd1) begin
              step_next = P_SPRA; bits_left_next = LenW'(28);
            end else if (sprite_next == 2'd2) begin
              step_next = P_WARP; bits_left_next = LenW'(9);
            end else begin
              step_next = P_NOT8; bits_left_next = LenW'(1);
            end
          end
          P_SPRA: begin step_next = P_SPRB; bits_left_next = LenW'(28); end
          P_SPRB: begin step_next = P_WARP; bits_left_next = LenW'(9); end
          P_WARP: begin
            if (sprite == 2'd1) begin step_next = P_LOWLAT; bits_left_next = LenW'(1); end
            else begin step_next = P_NOT8; bits_left_next = LenW'(1); end
          end
          P_LOWLAT: begin step_next = P_NOT8; bits_left_next = LenW'(1); end
          P_NOT8: begin
            if (v != '0) begin step_next = P_PREC; bits_left_next = LenW'(8); end
            else begin step_next = P_QTYPE; bits_left_next = LenW'(1); end
          end
          P_PREC: begin step_next = P_QTYPE; bits_left_next = LenW'(1); end
          P_QTYPE: begin
            if (v != '0) begin step_next = P_LOADI; bits_left_next = LenW'(1); end
            else begin step_next = P_PRE; bits_left_next = v1 ? LenW'(1) : LenW'(2); end
          end
          P_LOADI: begin
            mcount_next = '0;
            if (v != '0) begin step_next = P_MATI; bits_left_next = LenW'(8); end
            else begin step_next = P_LOADN; bits_left_next = LenW'(1); end
          end
          P_LOADN: begin
            mcount_next = '0;
            if (v != '0) begin step_next = P_MATN; bits_left_next = LenW'(8); end
            else begin step_next = P_PRE; bits_left_next = v1 ? LenW'(1) : LenW'(2); end
          end
          P_MATI, P_MATN: begin
            bits_left_next = LenW'(8);
            // a zero after the first entry ends the matrix early
            if ((mcount != '0 && v == '0) || (mc_inc >= CntW'(MatrixLen))) begin
              if (!(mcount != '0 && v == '0)) mcount_next = mc_inc;
              if (step == P_MATI) begin
                step_next = P_LOADN; bits_left_next = LenW'(1);
              end else begin
                step_next = P_PRE; bits_left_next = v1 ? LenW'(1) : LenW'(2);
              end
            end else begin
              mcount_next = mc_inc;
            end
          end
          P_PRE: begin step_next = P_RESYNC; bits_left_next = LenW'(1); end
          P_RESYNC: begin
            r_next.resync_used = (v == '0);
            step_next = P_DP; bits_left_next = LenW'(1);
          end
          P_DP, P_RVLC: begin
            if (step == P_DP) r_next.partitioned = (v != '0);
            else r_next.reversible_vlc = (v != '0);
            if (step == P_DP && v != '0) begin
              step_next = P_RVLC; bits_left_next = LenW'(1);
            end else if (!v1) begin
              step_next = P_NEWPRED; bits_left_next = LenW'(2);
            end else begin
              step_next = P_SCAL; bits_left_next = LenW'(1);
            end
          end
          P_NEWPRED: begin step_next = P_SCAL; bits_left_next = LenW'(1); end
          P_SCAL: begin
            if (v != '0) begin step_next = P_SCALX; bits_left_next = LenW'(27); end
            else begin hit = 1'b1; hit_st = ST_VOL_DONE; end
          end
          P_SCALX: begin hit = 1'b1; hit_st = ST_VOL_DONE; end
          default: begin
            step_next = P_SEARCH; bits_left_next = LenW'(8);
            if (search_stage == 2'd1) begin
              search_stage_next = (v == '0) ? 2'd2 : 2'd0;
            end else if (search_stage == 2'd2) begin
              search_stage_next = 2'd0;
              if (v == 32'd1) begin
                step_next = P_CODE;
              end else if (v[31:2] == 30'h20) begin
                hit = 1'b1; hit_st = ST_H263;
              end
            end else begin
              search_stage_next = (v == '0) ? 2'd1 : 2'd0;
            end
          end
        endcase
      end
    end
    rsp.done = 1'b0;
    rsp.status = hit_st;
    if (bit_in.bit_valid) begin
      if (hit) begin
        rsp.done = 1'b1;
      end else if (bit_in.last_bit && final_flag) begin
        rsp.done = 1'b1;
        rsp.status = (step_next == P_SEARCH && search_stage_next == 2'd0) ?
                     ST_NO_VOL : ST_TRUNCATED;
      end
    end
    rec = r_next;
  end

endmodule
`default_nettype wire

// ===== hdl/mpeg4_vol_header_parser.sv =====
`default_nettype none
// Header parser for MPEG-4 Part 2 decoder configuration: one header byte per
// request on s_axis, MSB first, one bit per clock through a byte shift
// register unless the output stalls; a byte is loaded, shifted out, then
// passes a turn-round state (shifting ends early inside the byte once the
// parse ends). At most one result per header buffer appears on m_axis, at
// the latest with the byte flagged final; bytes after an early result are
// taken without shifting and dropped. The output register lets the next byte
// load while a result waits; its bits only shift once that result is taken.
module mpeg4_vol_header_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // header_byte
  input  wire logic        s_axis_tlast,  // final_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // frame_width[12:0], frame_height[25:13], tick_resolution[41:26],
  // profile_level[49:42], resync_used[50], partitioned[51],
  // reversible_vlc[52], parse_status[55:53]
  output logic [m4vol_pkg::OutW-1:0] m_axis_tdata
);
  import m4vol_pkg::*;

  ctl_t             st, st_next;
  logic [ByteW-1:0] window;
  logic [3:0]       nleft;
  logic             fin;
  logic             finished;
  logic             clear;
  bit_req_t         breq;
  walk_rsp_t        wrsp;
  rec_t             rec;
  logic             load, out_busy;
  logic             adv;

  m4vol_walker u_walker (
    .clk        (clk),
    .rst        (rst),
    .clear      (clear),
    .bit_in     (breq),
    .final_flag (fin),
    .rsp        (wrsp),
    .rec        (rec)
  );

  assign out_busy = m_axis_tvalid && !m_axis_tready;
  assign s_axis_tready = (st == S_IDLE);
  assign load = s_axis_tvalid && s_axis_tready;
  // shifting holds while an earlier result still waits
  assign adv = (st == S_SHIFT) && !out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      nleft <= '0;
      fin <= 1'b0;
      finished <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      st <= st_next;
      if (adv && wrsp.done) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      if (load) begin
        fin <= s_axis_tlast;
        nleft <= 4'd8;
        if (finished && s_axis_tlast) finished <= 1'b0;
      end else if (adv) begin
        nleft <= nleft - 1'b1;
        if (wrsp.done) begin
          finished <= !fin;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) window <= s_axis_tdata;
    else if (adv) window <= {window[ByteW-2:0], 1'b0};
    if (adv && wrsp.done) begin
      m_axis_tdata <= {wrsp.status, rec.reversible_vlc, rec.partitioned,
                       rec.resync_used, rec.profile_level, rec.tick_resolution,
                       rec.frame_height, rec.frame_width};
    end
  end

  always_comb begin
    st_next = st;
    breq.bit_valid = adv;
    breq.bit_val = window[ByteW-1];
    breq.last_bit = (nleft == 4'd1);
    clear = 1'b0;
    case (st)
      S_IDLE: begin
        if (load) begin
          if (finished) begin
            st_next = S_IDLE;
          end else begin
            st_next = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        if (adv && (wrsp.done || nleft == 4'd1)) begin
          st_next = S_OUT;
        end
      end
      S_OUT: begin
        st_next = S_IDLE;
        clear = fin;
      end
      default: st_next = S_IDLE;
    endcase
    if (st == S_IDLE && load && finished && s_axis_tlast) clear = 1'b1;
  end

endmodule
`default_nettype wire
